// File: rtl/elg_pkg.sv
package elg_pkg;

  // Default operand width of the modular datapath.
  localparam int MOD_BITS_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_KEY  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_KEY = 8'd3;

  // Operation codes.
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] plain_value;
    logic [31:0] session_key;
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
  } in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
    logic        no_inverse;
  } out_t;

endpackage

// File: rtl/elgamal_modular_cipher.sv
// ElGamal engine over a configurable modulus. An encrypt word returns g^k and y^k*m mod p; a
// decrypt word returns c2*(c1^x)^-1 mod p, or zero with no_inverse set when no inverse exists.
// All modular multiplication runs through a single shift-and-add modular step unit that is
// reused under a sequencer; each quotient-and-coefficient step of the extended Euclidean
// algorithm also feeds its quotient bits through that unit. An encrypt word runs two 32-bit
// exponentiations, a decrypt word one exponentiation followed by the Euclid steps. Only one
// word is in flight; in_stall is high from acceptance until the result word has been taken.
// Configuration is to be written only while the engine is idle; it is not enforced.
module elgamal_modular_cipher import elg_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CW = 5;
  localparam logic [CW-1:0] MUL_LAST = 5'd31;
  localparam logic [CW-1:0] DIV_LAST = CW'(MOD_BITS - 1);

  typedef logic [MOD_BITS-1:0] val_t;
  typedef logic [MOD_BITS:0]   wide_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_POW_START, S_POW_BASE, S_POW_LOOP, S_POW_MULD, S_POW_SQD,
    S_E_POW1, S_E_POW2, S_E_MRED, S_E_FIN, S_D_POW, S_EUC_CHECK, S_DIV, S_EUC_UPD, S_D_FIN
  } state_t;

  logic [31:0] modulus, generator, public_key, private_key;
  in_t         item;
  out_t        res;
  state_t      state, ret_mul, ret_pow;
  logic        res_valid;
  val_t        p, base, acc, macc, ma, r0, r1, c0, c1, rem, dvd;
  logic [31:0] mb, pow_src, expo;
  logic [CW-1:0] cnt;

  val_t  p_in, step_out, rem_next, cn;
  wide_t pw, two, red1, sum, remsh, diff;
  logic  q_bit, step_bit;

  assign p_in = modulus[MOD_BITS-1:0];
  assign pw   = {1'b0, p};

  // Long-division bit: shift in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    remsh    = {rem, dvd[MOD_BITS-1]};
    q_bit    = remsh >= {1'b0, r1};
    rem_next = q_bit ? MOD_BITS'(remsh - {1'b0, r1}) : MOD_BITS'(remsh);
  end

  // Shared modular step: macc = 2*macc + bit*ma mod p, with macc and ma below p.
  always_comb begin
    step_bit = (state == S_DIV) ? q_bit : mb[31];
    two      = {macc, 1'b0};
    red1     = (two >= pw) ? two - pw : two;
    sum      = red1 + (step_bit ? {1'b0, ma} : '0);
    step_out = (sum >= pw) ? MOD_BITS'(sum - pw) : MOD_BITS'(sum);
  end

  // New Bezout coefficient: c0 - q*c1 mod p, with q*c1 mod p left in macc.
  always_comb begin
    diff = {1'b0, c0} + (pw - {1'b0, macc});
    cn   = (diff >= pw) ? MOD_BITS'(diff - pw) : MOD_BITS'(diff);
  end

  assign in_stall  = (state != S_IDLE) || res_valid;
  assign out_valid = res_valid;
  assign out_data  = res;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= 32'd10007;
      generator   <= 32'd2;
      public_key  <= 32'd1;
      private_key <= 32'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus     <= cfg_data;
        REG_GENERATOR:   generator   <= cfg_data;
        REG_PUBLIC_KEY:  public_key  <= cfg_data;
        REG_PRIVATE_KEY: private_key <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with its datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_mul   <= S_IDLE;
      ret_pow   <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_data;
            p    <= p_in;
            res  <= '0;
            if (p_in < val_t'(2)) begin
              res_valid <= 1'b1;
            end else if (in_data.action == ACT_ENCRYPT) begin
              pow_src <= generator;
              expo    <= in_data.session_key;
              ret_pow <= S_E_POW1;
              state   <= S_POW_START;
            end else begin
              pow_src <= in_data.cipher_first;
              expo    <= private_key;
              ret_pow <= S_D_POW;
              state   <= S_POW_START;
            end
          end
        end
        S_MUL: begin
          macc <= step_out;
          mb   <= mb << 1;
          cnt  <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            state <= ret_mul;
          end
        end
        S_POW_START: begin
          ma <= val_t'(1); mb <= pow_src; macc <= '0; cnt <= '0;
          ret_mul <= S_POW_BASE; state <= S_MUL;
        end
        S_POW_BASE: begin
          base  <= macc;
          acc   <= val_t'(1);
          state <= S_POW_LOOP;
        end
        S_POW_LOOP: begin
          macc <= '0; cnt <= '0; ma <= base;
          if (expo == '0) begin
            state <= ret_pow;
          end else if (expo[0]) begin
            mb <= 32'(acc); ret_mul <= S_POW_MULD; state <= S_MUL;
          end else begin
            mb <= 32'(base); ret_mul <= S_POW_SQD; state <= S_MUL;
          end
        end
        S_POW_MULD: begin
          acc <= macc;
          macc <= '0; cnt <= '0; ma <= base; mb <= 32'(base);
          ret_mul <= S_POW_SQD; state <= S_MUL;
        end
        S_POW_SQD: begin
          base  <= macc;
          expo  <= expo >> 1;
          state <= S_POW_LOOP;
        end
        S_E_POW1: begin
          res.result_first <= 32'(acc);
          pow_src <= public_key;
          expo    <= item.session_key;
          ret_pow <= S_E_POW2;
          state   <= S_POW_START;
        end
        S_E_POW2: begin
          ma <= val_t'(1); mb <= item.plain_value; macc <= '0; cnt <= '0;
          ret_mul <= S_E_MRED; state <= S_MUL;
        end
        S_E_MRED: begin
          ma <= acc; mb <= 32'(macc); macc <= '0; cnt <= '0;
          ret_mul <= S_E_FIN; state <= S_MUL;
        end
        S_E_FIN: begin
          res.result_second <= 32'(macc);
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_D_POW: begin
          r0 <= acc; r1 <= p; c0 <= val_t'(1); c1 <= '0;
          state <= S_EUC_CHECK;
        end
        S_EUC_CHECK: begin
          macc <= '0; cnt <= '0;
          if (r1 == '0) begin
            if (r0 == val_t'(1)) begin
              ma <= val_t'(1); mb <= item.cipher_second;
              ret_mul <= S_D_FIN; state <= S_MUL;
            end else begin
              res.no_inverse <= 1'b1;
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            rem <= '0; dvd <= r0; ma <= c1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          macc <= step_out;
          rem  <= rem_next;
          dvd  <= dvd << 1;
          cnt  <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_EUC_UPD;
          end
        end
        S_EUC_UPD: begin
          r0 <= r1; r1 <= rem; c0 <= c1; c1 <= cn;
          state <= S_EUC_CHECK;
        end
        S_D_FIN: begin
          if (ret_mul == S_D_FIN && mb == '0 && cnt == '0) begin
            // Reduced c2 is ready: multiply it by the inverse.
            ma <= c0; mb <= 32'(macc); macc <= '0;
            ret_mul <= S_IDLE; state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
      // The final multiply returns to idle: publish its product.
      if (state == S_MUL && cnt == MUL_LAST && ret_mul == S_IDLE) begin
        res.result_first <= 32'(step_out);
        res_valid <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/elg_checker.sv
module elg_checker import elg_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A word taken in blocks the input until its result has gone.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // A delivered result is not repeated.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result word repeated");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A missing inverse gives zero result fields.
  a_no_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_inverse |->
      out_data.result_first == 32'd0 && out_data.result_second == 32'd0)
    else $error("no_inverse with non-zero result");

endmodule

bind elgamal_modular_cipher elg_checker u_elg_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
